// ===== hdl/m4vt_pkg.sv =====
// Shared constants, types and reset values for the 4x4 matrix-vector transform.
package m4vt_pkg;

  // Fixed-point format and widths
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int DIM        = 4;

  // Configuration register file
  localparam int NUM_REGS   = 8;
  localparam int REG_SEL_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  // 1.0 in the fixed-point format, kept to 32 bits
  localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(64'd1 << FRAC_BITS);

  typedef logic [DATA_W-1:0]     comp_t;
  typedef comp_t [DIM-1:0]       vec_t;   // vec[k]
  typedef vec_t  [DIM-1:0]       mat_t;   // mat[k][j], row k, column j
  typedef logic [CFG_DATA_W-1:0] cfg_word_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef sum_t  [DIM-1:0]       sum_vec_t;

  // Item handed from the MAC pipe to the round/saturate stage
  typedef struct packed {
    logic     valid;
    sum_vec_t sums;
  } m4vt_sum_item_t;

  // Identity matrix packed into the register layout:
  // register 2j+h holds column j, rows 2h (low half) and 2h+1 (high half).
  function automatic cfg_word_t reset_value(input int idx);
    cfg_word_t w;
    int        col;
    w   = '0;
    col = idx >> 1;
    if (((col >> 1) & 1) == (idx & 1)) begin
      if ((col & 1) != 0) begin
        w[CFG_DATA_W-1:DATA_W] = ONE_FIX;
      end else begin
        w[DATA_W-1:0] = ONE_FIX;
      end
    end
    return w;
  endfunction

endpackage

// ===== hdl/m4vt_vec_if.sv =====
// Input channel carrying one 4-component vector item.
interface m4vt_vec_if import m4vt_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t in_x;
  comp_t in_y;
  comp_t in_z;
  comp_t in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                  output ready);
endinterface

// ===== hdl/m4vt_res_if.sv =====
// Result channel carrying one transformed vector item and its saturation flag.
interface m4vt_res_if import m4vt_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  comp_t out_w;
  logic  saturated;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  output saturated, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  input saturated, output ready);
endinterface

// ===== hdl/m4vt_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface m4vt_cfg_if import m4vt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  cfg_word_t            data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/m4vt_matrix_regs.sv =====
// Matrix configuration registers, reset to identity, unpacked to entry form.
module m4vt_matrix_regs import m4vt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  cfg_word_t            wr_data,
  output mat_t                 mat
);

  cfg_word_t regs_r [NUM_REGS];

  // Writes always accepted; indexes past the register file are dropped
  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= reset_value(i);
      end
    end else if (wr_valid && (wr_index < CFG_IDX_W'(NUM_REGS))) begin
      regs_r[wr_index[REG_SEL_W-1:0]] <= wr_data;
    end
  end

  // Entry [k][j]: column j in registers 2j/2j+1, odd rows in the high half
  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      for (int j = 0; j < DIM; j++) begin
        if ((k & 1) != 0) begin
          mat[k][j] = regs_r[REG_SEL_W'((j << 1) | (k >> 1))][CFG_DATA_W-1:DATA_W];
        end else begin
          mat[k][j] = regs_r[REG_SEL_W'((j << 1) | (k >> 1))][DATA_W-1:0];
        end
      end
    end
  end

endmodule

// ===== hdl/m4vt_mac_pipe.sv =====
// Three-stage multiply / pair-add / final-add pipeline producing exact sums.
module m4vt_mac_pipe import m4vt_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  mat_t           mat,
  input  logic           in_valid,
  output logic           in_ready,
  input  vec_t           in_vec,
  output m4vt_sum_item_t sum_item,
  input  logic           sum_ready
);

  logic              prod_v_r;
  logic [PROD_W-1:0] prod_r [DIM][DIM];   // [k][j]
  logic              pair_v_r;
  logic [PAIR_W-1:0] pair_r [DIM][2];     // [j][half]
  logic              sum_v_r;
  sum_vec_t          sum_r;

  logic en_prod;
  logic en_pair;
  logic en_sum;

  // A stage loads when it is empty or its contents move on
  assign en_sum   = !sum_v_r  || sum_ready;
  assign en_pair  = !pair_v_r || en_sum;
  assign en_prod  = !prod_v_r || en_pair;
  assign in_ready = en_prod;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      pair_v_r <= 1'b0;
      sum_v_r  <= 1'b0;
    end else begin
      if (en_prod) prod_v_r <= in_valid;
      if (en_pair) pair_v_r <= prod_v_r;
      if (en_sum)  sum_v_r  <= pair_v_r;
    end
  end

  // Stage 1: sixteen signed 32x32 products
  always_ff @(posedge clk) begin
    if (en_prod) begin
      for (int k = 0; k < DIM; k++) begin
        for (int j = 0; j < DIM; j++) begin
          prod_r[k][j] <= PROD_W'($signed(mat[k][j])) * PROD_W'($signed(in_vec[k]));
        end
      end
    end
  end

  // Stage 2: rows 0+1 and rows 2+3 per column
  always_ff @(posedge clk) begin
    if (en_pair) begin
      for (int j = 0; j < DIM; j++) begin
        pair_r[j][0] <= PAIR_W'($signed(prod_r[0][j])) + PAIR_W'($signed(prod_r[1][j]));
        pair_r[j][1] <= PAIR_W'($signed(prod_r[2][j])) + PAIR_W'($signed(prod_r[3][j]));
      end
    end
  end

  // Stage 3: full column sum
  always_ff @(posedge clk) begin
    if (en_sum) begin
      for (int j = 0; j < DIM; j++) begin
        sum_r[j] <= SUM_W'($signed(pair_r[j][0])) + SUM_W'($signed(pair_r[j][1]));
      end
    end
  end

  assign sum_item.valid = sum_v_r;
  assign sum_item.sums  = sum_r;

endmodule

// ===== hdl/m4vt_round_sat.sv =====
// Floor shift by the fraction width, saturate to 32 bits, output register.
module m4vt_round_sat import m4vt_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  m4vt_sum_item_t sum_item,
  output logic           sum_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output vec_t           out_vec,
  output logic           out_sat
);

  localparam int HI_W = SUM_W - DATA_W + 1;

  logic     out_v_r;
  vec_t     out_vec_r;
  logic     out_sat_r;
  vec_t     res_nxt;
  logic     sat_nxt;
  logic     load;

  assign load      = !out_v_r || out_ready;
  assign sum_ready = load;

  // Arithmetic shift is floor; overflow when bits above the sign disagree
  always_comb begin
    sum_t            shifted;
    logic [HI_W-1:0] hi;
    sat_nxt = 1'b0;
    for (int j = 0; j < DIM; j++) begin
      shifted = sum_t'($signed(sum_item.sums[j]) >>> FRAC_BITS);
      hi      = shifted[SUM_W-1:DATA_W-1];
      if ((&hi) || !(|hi)) begin
        res_nxt[j] = shifted[DATA_W-1:0];
      end else begin
        sat_nxt    = 1'b1;
        res_nxt[j] = shifted[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= sum_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_vec_r <= res_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_vec   = out_vec_r;
  assign out_sat   = out_sat_r;

endmodule

// ===== hdl/mat4_vector_transform.sv =====
// Top level of the 4x4 matrix-vector transform.
// Multiplies each input vector (x, y, z, w; signed Q16.16) by a 4x4 matrix held in eight
// 64-bit configuration registers (reset to identity): out[j] = sum over k of M[k][j]*in[k],
// with exact 64-bit products, floor shift by 16 and saturation to 32 bits; saturated flags
// any clipped component. One item is taken per clock with no gaps while the output is not stalled;
// an item's result passes four register stages (multiply with sixteen 32x32 multipliers,
// pair-add, final add, round/saturate output register). Back pressure stalls only the
// stages that are full, so bubbles are squeezed out. Configuration writes are always
// accepted; writes to indexes above 7 are ignored. Write the matrix only while idle.
module mat4_vector_transform import m4vt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  m4vt_vec_if.sink    in_ch,
  m4vt_res_if.source  out_ch,
  m4vt_cfg_if.sink    cfg_ch
);

  mat_t           mat;
  vec_t           in_vec;
  vec_t           out_vec;
  m4vt_sum_item_t sum_item;
  logic           sum_ready;

  assign in_vec[0] = in_ch.in_x;
  assign in_vec[1] = in_ch.in_y;
  assign in_vec[2] = in_ch.in_z;
  assign in_vec[3] = in_ch.in_w;

  m4vt_matrix_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .mat      (mat)
  );

  m4vt_mac_pipe u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat       (mat),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_vec    (in_vec),
    .sum_item  (sum_item),
    .sum_ready (sum_ready)
  );

  m4vt_round_sat u_rsat (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_item  (sum_item),
    .sum_ready (sum_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_vec   (out_vec),
    .out_sat   (out_ch.saturated)
  );

  assign out_ch.out_x = out_vec[0];
  assign out_ch.out_y = out_vec[1];
  assign out_ch.out_z = out_vec[2];
  assign out_ch.out_w = out_vec[3];

endmodule

// ===== tb/mat4_vector_transform_test.sv =====
// Self-checking testbench for the 4x4 matrix-vector transform: directed table, then random phases.
module mat4_vector_transform_test;
  import m4vt_pkg::*;

  // Expected or observed result item
  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
    logic  sat;
  } xform_t;

  typedef enum logic {ROW_VEC, ROW_CFG} row_kind_t;

  // One row of the directed stimulus table
  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    cfg_word_t            word;
    vec_t                 v;
    bit                   has_exp;
    xform_t               exp_res;
  } stim_row_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COL0_ROWS01 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL0_ROWS23 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL1_ROWS01 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL1_ROWS23 = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COL2_ROWS01 = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COL2_ROWS23 = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COL3_ROWS01 = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COL3_ROWS23 = 8'd7;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

  localparam comp_t     C_MAX  = 32'h7FFF_FFFF;
  localparam comp_t     C_MIN  = 32'h8000_0000;
  localparam cfg_word_t ID_LO  = {32'd0, ONE_FIX};
  localparam cfg_word_t ID_HI  = {ONE_FIX, 32'd0};
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(C_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - 1;

  localparam int LATENCY     = 4;
  localparam int TAIL        = 4 * LATENCY;
  localparam int HOLD_CYCLES = 64;
  localparam int HOLD_PHASE  = 2;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 158;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_SHOWN   = 10;

  logic clk;
  logic rst_n;

  m4vt_vec_if in_if ();
  m4vt_res_if out_if ();
  m4vt_cfg_if cfg_if ();

  mat4_vector_transform dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Shadow matrix, expected results, run state
  cfg_word_t mat_words [NUM_REGS];
  xform_t    xform_q [$];
  stim_row_t stim_tab [$];
  xform_t    pend_exp;
  bit        pend_has;
  bit        idle_on;
  bit        hold_req;
  bit        dirty;
  int        err_count;
  int        cycles;
  int        hold_left;
  int        stall_left;
  bit        hold_armed;
  xform_t    got_res;
  xform_t    want_res;

  // Clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic cfg_word_t identity_word(int r);
    case (r)
      0, 5:    return ID_LO;
      2, 7:    return ID_HI;
      default: return '0;
    endcase
  endfunction

  // Expected transform of one vector by the shadow matrix
  function automatic xform_t transform(vec_t v);
    xform_t                    r;
    logic signed [SUM_W-1:0]   acc;
    logic signed [SUM_W-1:0]   shifted;
    logic signed [DATA_W-1:0]  m;
    logic signed [DATA_W-1:0]  a;
    logic signed [PROD_W-1:0]  prod;
    cfg_word_t                 word;
    comp_t                     c [DIM];
    bit                        sat;
    sat = 1'b0;
    for (int j = 0; j < DIM; j++) begin
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        word = mat_words[2 * j + k / 2];
        m    = (k % 2 != 0) ? word[CFG_DATA_W-1:DATA_W] : word[DATA_W-1:0];
        a    = v[k];
        prod = PROD_W'(m) * PROD_W'(a);
        acc  = acc + prod;
      end
      shifted = acc >>> FRAC_BITS;
      if (shifted > SUM_MAX) begin
        c[j] = C_MAX;
        sat  = 1'b1;
      end else if (shifted < SUM_MIN) begin
        c[j] = C_MIN;
        sat  = 1'b1;
      end else begin
        c[j] = shifted[DATA_W-1:0];
      end
    end
    r.x   = c[0];
    r.y   = c[1];
    r.z   = c[2];
    r.w   = c[3];
    r.sat = sat;
    return r;
  endfunction

  // Random values
  function automatic comp_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return '0;
      3:       return ONE_FIX;
      default: return -ONE_FIX;
    endcase
  endfunction

  function automatic comp_t small_fix();
    return $urandom_range(0, 2 ** 19) - 2 ** 18;  // about -4.0 .. 4.0
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2, 3:    return small_fix();
      4:       return pick_extreme();
      default: return ($urandom_range(0, 200) - 100) << FRAC_BITS;
    endcase
  endfunction

  // Matrix entry [k][j] for a phase style: full random, small, extremes, affine
  function automatic comp_t rand_entry(int style, int k, int j);
    case (style)
      0:       return $urandom;
      1:       return small_fix();
      2:       return pick_extreme();
      default: return (k == j) ? ONE_FIX : ((k == 3) ? small_fix() : '0);
    endcase
  endfunction

  function automatic vec_t rand_vec(int style);
    vec_t v;
    for (int k = 0; k < DIM; k++) v[k] = rand_comp();
    if (style == 3 && $urandom_range(0, 1) == 1) v[3] = ONE_FIX;
    return v;
  endfunction

  // Table builders
  task automatic add_vec(comp_t x, comp_t y, comp_t z, comp_t w);
    stim_row_t row;
    row.kind    = ROW_VEC;
    row.idx     = '0;
    row.word    = '0;
    row.v       = {w, z, y, x};
    row.has_exp = 1'b0;
    row.exp_res = '0;
    stim_tab.push_back(row);
  endtask

  task automatic add_chk(comp_t x, comp_t y, comp_t z, comp_t w,
                         comp_t ex, comp_t ey, comp_t ez, comp_t ew, logic es);
    stim_row_t row;
    row.kind    = ROW_VEC;
    row.idx     = '0;
    row.word    = '0;
    row.v       = {w, z, y, x};
    row.has_exp = 1'b1;
    row.exp_res = {ex, ey, ez, ew, es};
    stim_tab.push_back(row);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, cfg_word_t word);
    stim_row_t row;
    row.kind    = ROW_CFG;
    row.idx     = idx;
    row.word    = word;
    row.v       = '0;
    row.has_exp = 1'b0;
    row.exp_res = '0;
    stim_tab.push_back(row);
  endtask

  task automatic add_fill(cfg_word_t word);
    for (int r = 0; r < NUM_REGS; r++) add_cfg(REG_COL0_ROWS01 + CFG_IDX_W'(r), word);
  endtask

  // Offer one vector item, with random idle first, and wait for the handshake
  task automatic send_vec(vec_t v, bit has, xform_t e);
    cfg_if.valid <= 1'b0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.in_x  <= v[0];
    in_if.in_y  <= v[1];
    in_if.in_z  <= v[2];
    in_if.in_w  <= v[3];
    pend_has    <= has;
    pend_exp    <= e;
    dirty = 1'b1;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Valid is left high; the next vector item lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t word);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= word;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // Stop sending and wait until the pipe is empty
  task automatic drain();
    if (dirty) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while (xform_q.size() != 0) @(posedge clk);
      repeat (LATENCY + 2) @(posedge clk);
      dirty = 1'b0;
    end
  endtask

  // Shadow register file
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_REGS; r++) mat_words[r] <= identity_word(r);
    end else if (cfg_if.valid && cfg_if.ready && cfg_if.index < NUM_REGS) begin
      mat_words[cfg_if.index] <= cfg_if.data;
    end
  end

  // Accepted input item: queue its expected result
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      if (pend_has) begin
        xform_q.push_back(pend_exp);
      end else begin
        xform_q.push_back(transform({in_if.in_w, in_if.in_z, in_if.in_y, in_if.in_x}));
      end
    end
  end

  // Result receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (!hold_req) begin
      hold_armed = 1'b1;
    end else if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_res = {out_if.out_x, out_if.out_y, out_if.out_z, out_if.out_w, out_if.saturated};
      if (xform_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("cycle %0d: result with nothing expected: x=%h y=%h z=%h w=%h sat=%b",
                   cycles, got_res.x, got_res.y, got_res.z, got_res.w, got_res.sat);
      end else begin
        want_res = xform_q.pop_front();
        if (got_res.x !== want_res.x || got_res.y !== want_res.y ||
            got_res.z !== want_res.z || got_res.w !== want_res.w ||
            got_res.sat !== want_res.sat) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("cycle %0d: expected x=%h y=%h z=%h w=%h sat=%b, got x=%h y=%h z=%h w=%h sat=%b",
                     cycles, want_res.x, want_res.y, want_res.z, want_res.w, want_res.sat,
                     got_res.x, got_res.y, got_res.z, got_res.w, got_res.sat);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mat4_vector_transform_test failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    vec_t v;
    int   style;
    initial_drive: begin
      rst_n        = 1'b0;
      in_if.valid  = 1'b0;
      in_if.in_x   = '0;
      in_if.in_y   = '0;
      in_if.in_z   = '0;
      in_if.in_w   = '0;
      cfg_if.valid = 1'b0;
      cfg_if.index = '0;
      cfg_if.data  = '0;
      out_if.ready = 1'b0;
      pend_has     = 1'b0;
      pend_exp     = '0;
      idle_on      = 1'b1;
      hold_req     = 1'b0;
      dirty        = 1'b0;
    end

    // Identity after reset, field extremes pass through unchanged
    add_chk('0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    add_chk(ONE_FIX, -ONE_FIX, 32'h0002_8000, 32'hFFFF_8000,
            ONE_FIX, -ONE_FIX, 32'h0002_8000, 32'hFFFF_8000, 1'b0);
    add_chk(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0);
    add_chk(C_MIN, C_MAX, 32'hFFFF_FFFF, 32'h1, C_MIN, C_MAX, 32'hFFFF_FFFF, 32'h1, 1'b0);
    // Writes to unmapped indexes leave the matrix alone
    add_cfg(REG_UNMAPPED_LO, '1);
    add_cfg(REG_UNMAPPED_HI, '1);
    add_chk(ONE_FIX, ONE_FIX, ONE_FIX, ONE_FIX, ONE_FIX, ONE_FIX, ONE_FIX, ONE_FIX, 1'b0);
    // All entries at max: overflow both ways
    add_fill({C_MAX, C_MAX});
    add_chk(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1);
    add_chk(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
    add_chk(32'h1, '0, '0, '0, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 1'b0);
    add_vec(C_MAX, C_MIN, '0, 32'h1234_5678);
    // All entries at min
    add_fill({C_MIN, C_MIN});
    add_chk(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1);
    add_chk(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1);
    add_chk(32'h1, '0, '0, '0, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 1'b0);
    // Zero matrix
    add_fill('0);
    add_chk(C_MAX, C_MIN, C_MAX, C_MIN, '0, '0, '0, '0, 1'b0);
    // Only column 0 overflows
    add_cfg(REG_COL0_ROWS01, {C_MAX, C_MAX});
    add_cfg(REG_COL0_ROWS23, {C_MAX, C_MAX});
    add_cfg(REG_COL1_ROWS01, ID_HI);
    add_cfg(REG_COL1_ROWS23, '0);
    add_cfg(REG_COL2_ROWS01, '0);
    add_cfg(REG_COL2_ROWS23, ID_LO);
    add_cfg(REG_COL3_ROWS01, '0);
    add_cfg(REG_COL3_ROWS23, ID_HI);
    add_vec(C_MAX, C_MAX, C_MAX, C_MAX);
    add_vec(ONE_FIX, 32'h0002_0000, -ONE_FIX, C_MIN);
    add_vec(32'h0000_0100, 32'hFFFF_FF00, 32'h0003_0000, 32'h0000_8000);

    // Reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        drain();
        write_reg(stim_tab[i].idx, stim_tab[i].word);
      end else begin
        send_vec(stim_tab[i].v, stim_tab[i].has_exp, stim_tab[i].exp_res);
      end
    end

    // Random phases, each with a fresh matrix
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      style = p % 4;
      for (int r = 0; r < NUM_REGS; r++) begin
        write_reg(REG_COL0_ROWS01 + CFG_IDX_W'(r),
                  {rand_entry(style, 2 * (r % 2) + 1, r / 2),
                   rand_entry(style, 2 * (r % 2), r / 2)});
      end
      if (p % 3 == 1)
        write_reg(REG_UNMAPPED_LO + CFG_IDX_W'($urandom_range(0, 247)), {$urandom, $urandom});
      idle_on  = (p != NUM_PHASES - 1) && (p % 5 != 4);
      hold_req <= (p == HOLD_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        v = rand_vec(style);
        send_vec(v, 1'b0, '0);
        if (n == 4) hold_req <= 1'b0;
      end
    end

    // Wind down
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (xform_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (err_count == 0 && xform_q.size() == 0) begin
      $display("mat4_vector_transform_test passed");
    end else begin
      $display("mat4_vector_transform_test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/m4vt_pkg.sv
hdl/m4vt_vec_if.sv
hdl/m4vt_res_if.sv
hdl/m4vt_cfg_if.sv
hdl/m4vt_matrix_regs.sv
hdl/m4vt_mac_pipe.sv
hdl/m4vt_round_sat.sv
hdl/mat4_vector_transform.sv
tb/mat4_vector_transform_test.sv
